@@ hw/rtl/hsv2grb_pkg.sv @@
// Package for the HSV to GRB pixel core: item and result types, hue sector
// codes and fixed-point constants. Depends on nothing else.
package hsv2grb_pkg;

    // Input item: hue in 1/16 degree, saturation and value in Q1.8
    typedef struct packed {
        logic [12:0] hue;
        logic [8:0]  saturation;
        logic [8:0]  brightness;
    } t_item;

    // Result item: packed green, red, blue and the range flag
    typedef struct packed {
        logic [23:0] pixel_word;
        logic        invalid;
    } t_result;

    // Hue sectors of 60 degrees each
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW    = 3'd0,
        SECTOR_YELLOW_GREEN  = 3'd1,
        SECTOR_GREEN_CYAN    = 3'd2,
        SECTOR_CYAN_BLUE     = 3'd3,
        SECTOR_BLUE_MAGENTA  = 3'd4,
        SECTOR_MAGENTA_RED   = 3'd5
    } t_sector;

    localparam logic [12:0] HUE_CIRCLE = 13'd5760;
    localparam logic [9:0]  HUE_SECTOR = 10'd960;
    localparam logic [8:0]  Q_ONE      = 9'd256;
    localparam logic [7:0]  CH_MAX     = 8'd255;
    // 256 * 960: unity in the q and t factor scale
    localparam logic [17:0] FULL_SCALE = 18'd245760;
    // ceil(2^19 / 15): exact floor(y / 15) for y below 4096
    localparam logic [15:0] RECIP_15   = 16'd34953;

endpackage

@@ hw/rtl/hsv_to_grb_pixel_core.sv @@
// HSV to GRB pixel core: five-stage pipeline from colour to packed pixel.
// Each accepted item passes stage registers r1 to r5 before the result strobe; one item per cycle.
// Throughput is set by the pipeline registers alone: busy stays low and a new item
// may be started on every cycle. The receiver cannot stall the result strobe.
// Synchronous active-low reset clears the stage valid bits; no item is in flight after it.
// Depends on hsv2grb_pkg.
module hsv_to_grb_pixel_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  hsv2grb_pkg::t_item  i_item,
    output logic                busy,
    output logic                o_valid,
    output hsv2grb_pkg::t_result o_result
);

    // Clamp a 9-bit channel to 8 bits
    function automatic logic [7:0] sat8(input logic [8:0] x);
        sat8 = x[8] ? hsv2grb_pkg::CH_MAX : x[7:0];
    endfunction

    logic accept;
    assign accept = start && !busy;
    assign busy   = 1'b0;

    // ---------------- stage 1: range check, wrap, sector and fraction
    logic                  n1_bad;
    logic [12:0]           n1_hue;
    hsv2grb_pkg::t_sector  n1_sector;
    logic [12:0]           n1_base;
    logic                  r1_valid, r1_bad;
    hsv2grb_pkg::t_sector  r1_sector;
    logic [9:0]            r1_frac;
    logic [8:0]            r1_sat, r1_val;

    always_comb begin
        n1_bad = (i_item.hue > hsv2grb_pkg::HUE_CIRCLE) ||
                 (i_item.saturation > hsv2grb_pkg::Q_ONE) ||
                 (i_item.brightness > hsv2grb_pkg::Q_ONE);
        n1_hue = (i_item.hue == hsv2grb_pkg::HUE_CIRCLE) ? 13'd0 : i_item.hue;
        if (n1_hue >= 13'd4800) begin
            n1_sector = hsv2grb_pkg::SECTOR_MAGENTA_RED;
            n1_base   = 13'd4800;
        end else if (n1_hue >= 13'd3840) begin
            n1_sector = hsv2grb_pkg::SECTOR_BLUE_MAGENTA;
            n1_base   = 13'd3840;
        end else if (n1_hue >= 13'd2880) begin
            n1_sector = hsv2grb_pkg::SECTOR_CYAN_BLUE;
            n1_base   = 13'd2880;
        end else if (n1_hue >= 13'd1920) begin
            n1_sector = hsv2grb_pkg::SECTOR_GREEN_CYAN;
            n1_base   = 13'd1920;
        end else if (n1_hue >= 13'd960) begin
            n1_sector = hsv2grb_pkg::SECTOR_YELLOW_GREEN;
            n1_base   = 13'd960;
        end else begin
            n1_sector = hsv2grb_pkg::SECTOR_RED_YELLOW;
            n1_base   = 13'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= accept;
        end
        r1_bad    <= n1_bad;
        r1_sector <= n1_sector;
        r1_frac   <= 10'(n1_hue - n1_base);
        r1_sat    <= i_item.saturation;
        r1_val    <= i_item.brightness;
    end

    // ---------------- stage 2: saturation products and q/t factors
    logic [17:0] n2_sf, n2_sg;
    logic [9:0]  n2_rest;
    logic        r2_valid, r2_bad;
    hsv2grb_pkg::t_sector r2_sector;
    logic [8:0]  r2_val;
    logic [16:0] r2_p_prod;
    logic [17:0] r2_q_fac, r2_t_fac;

    always_comb begin
        n2_rest = hsv2grb_pkg::HUE_SECTOR - r1_frac;
        n2_sf   = 18'(r1_sat * r1_frac);
        n2_sg   = 18'(r1_sat * n2_rest);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_bad    <= r1_bad;
        r2_sector <= r1_sector;
        r2_val    <= r1_val;
        r2_p_prod <= 17'(r1_val * (hsv2grb_pkg::Q_ONE - r1_sat));
        r2_q_fac  <= hsv2grb_pkg::FULL_SCALE - n2_sf;
        r2_t_fac  <= hsv2grb_pkg::FULL_SCALE - n2_sg;
    end

    // ---------------- stage 3: scale the q and t factors by value
    logic        r3_valid, r3_bad;
    hsv2grb_pkg::t_sector r3_sector;
    logic [8:0]  r3_val;
    logic [16:0] r3_p_prod;
    logic [25:0] r3_q_prod, r3_t_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_bad    <= r2_bad;
        r3_sector <= r2_sector;
        r3_val    <= r2_val;
        r3_p_prod <= r2_p_prod;
        r3_q_prod <= 26'(r2_val * r2_q_fac);
        r3_t_prod <= 26'(r2_val * r2_t_fac);
    end

    // ---------------- stage 4: divide q and t by 256*960, p by 256, and clamp to 8 bits
    // Shift out 2^14, then divide by 15 through a reciprocal multiply
    logic [27:0] n4_q_mul, n4_t_mul;
    logic        r4_valid, r4_bad;
    hsv2grb_pkg::t_sector r4_sector;
    logic [7:0]  r4_v8, r4_p8, r4_q8, r4_t8;

    always_comb begin
        n4_q_mul = 28'(r3_q_prod[25:14] * hsv2grb_pkg::RECIP_15);
        n4_t_mul = 28'(r3_t_prod[25:14] * hsv2grb_pkg::RECIP_15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
        r4_bad    <= r3_bad;
        r4_sector <= r3_sector;
        r4_v8     <= sat8(r3_val);
        r4_p8     <= sat8(r3_p_prod[16:8]);
        r4_q8     <= sat8(n4_q_mul[27:19]);
        r4_t8     <= sat8(n4_t_mul[27:19]);
    end

    // ---------------- stage 5: route channels by sector and pack
    logic [7:0] n5_r, n5_g, n5_b;
    logic       r5_valid;
    hsv2grb_pkg::t_result r5_result;

    always_comb begin
        case (r4_sector)
            hsv2grb_pkg::SECTOR_RED_YELLOW: begin
                n5_r = r4_v8; n5_g = r4_t8; n5_b = r4_p8;
            end
            hsv2grb_pkg::SECTOR_YELLOW_GREEN: begin
                n5_r = r4_q8; n5_g = r4_v8; n5_b = r4_p8;
            end
            hsv2grb_pkg::SECTOR_GREEN_CYAN: begin
                n5_r = r4_p8; n5_g = r4_v8; n5_b = r4_t8;
            end
            hsv2grb_pkg::SECTOR_CYAN_BLUE: begin
                n5_r = r4_p8; n5_g = r4_q8; n5_b = r4_v8;
            end
            hsv2grb_pkg::SECTOR_BLUE_MAGENTA: begin
                n5_r = r4_t8; n5_g = r4_p8; n5_b = r4_v8;
            end
            default: begin
                n5_r = r4_v8; n5_g = r4_p8; n5_b = r4_q8;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_result.invalid    <= r4_bad;
        r5_result.pixel_word <= r4_bad ? 24'd0 : {n5_g, n5_r, n5_b};
    end

    assign o_valid  = r5_valid;
    assign o_result = r5_result;

endmodule

@@ tb/hsv_to_grb_pixel_core_tb.sv @@
// Self-checking testbench for hsv_to_grb_pixel_core: HSV colours in, packed GRB pixels out.
// Drives directed and random colours, predicts each pixel in place and checks every strobe.
// Depends on hsv2grb_pkg and hsv_to_grb_pixel_core.
`timescale 1ns / 1ps

module hsv_to_grb_pixel_core_tb;

    localparam int unsigned RANDOM_COLOURS = 1850;
    localparam int unsigned CYCLE_LIMIT    = 200000;
    localparam int unsigned TAIL_CYCLES    = 12;
    localparam int unsigned IDLE_PERCENT   = 28;
    localparam int unsigned BURST_FIRST    = 700;
    localparam int unsigned BURST_LAST     = 1000;

    // One colour waiting to be sent; drain_first holds it until the pipe is empty
    typedef struct {
        hsv2grb_pkg::t_item colour;
        bit                 drain_first;
    } t_pending_colour;

    logic                 i_clk   = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start   = 1'b0;
    hsv2grb_pkg::t_item   i_item  = '0;
    logic                 busy;
    logic                 o_valid;
    hsv2grb_pkg::t_result o_result;

    t_pending_colour      colour_queue[$];
    hsv2grb_pkg::t_result expected_pixels[$];

    int unsigned colours_total    = 0;
    int unsigned colours_launched = 0;
    int unsigned colours_accepted = 0;
    int unsigned pixels_checked   = 0;
    int unsigned invalid_seen     = 0;
    int unsigned drains_done      = 0;
    int unsigned mismatches       = 0;
    int unsigned cycle_count      = 0;

    hsv_to_grb_pixel_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_item   (i_item),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Clamp a scaled channel to 8 bits
    function automatic logic [7:0] clamp_channel(int unsigned x);
        return (x > hsv2grb_pkg::CH_MAX) ? hsv2grb_pkg::CH_MAX : x[7:0];
    endfunction

    // Work out the pixel word and range flag for one colour
    function automatic hsv2grb_pkg::t_result predict_pixel(hsv2grb_pkg::t_item colour);
        int unsigned          h, s, v, f, full, circle, sector_len, one;
        logic [7:0]           v8, p8, q8, t8, red, grn, blu;
        hsv2grb_pkg::t_sector sector;
        hsv2grb_pkg::t_result pixel;
        pixel      = '0;
        circle     = int'(hsv2grb_pkg::HUE_CIRCLE);
        sector_len = int'(hsv2grb_pkg::HUE_SECTOR);
        one        = int'(hsv2grb_pkg::Q_ONE);
        full       = int'(hsv2grb_pkg::FULL_SCALE);
        h          = int'(colour.hue);
        s          = int'(colour.saturation);
        v          = int'(colour.brightness);
        if (h > circle || s > one || v > one) begin
            pixel.invalid = 1'b1;
            return pixel;
        end
        if (h == circle)
            h = 0;
        sector = hsv2grb_pkg::t_sector'(3'(h / sector_len));
        f    = h % sector_len;
        v8   = clamp_channel(v);
        p8   = clamp_channel((v * (one - s)) / one);
        q8   = clamp_channel((v * (full - s * f)) / full);
        t8   = clamp_channel((v * (full - s * (sector_len - f))) / full);
        red  = '0;
        grn  = '0;
        blu  = '0;
        case (sector)
            hsv2grb_pkg::SECTOR_RED_YELLOW: begin
                red = v8; grn = t8; blu = p8;
            end
            hsv2grb_pkg::SECTOR_YELLOW_GREEN: begin
                red = q8; grn = v8; blu = p8;
            end
            hsv2grb_pkg::SECTOR_GREEN_CYAN: begin
                red = p8; grn = v8; blu = t8;
            end
            hsv2grb_pkg::SECTOR_CYAN_BLUE: begin
                red = p8; grn = q8; blu = v8;
            end
            hsv2grb_pkg::SECTOR_BLUE_MAGENTA: begin
                red = t8; grn = p8; blu = v8;
            end
            hsv2grb_pkg::SECTOR_MAGENTA_RED: begin
                red = v8; grn = p8; blu = q8;
            end
            default: ;
        endcase
        pixel.pixel_word = {grn, red, blu};
        return pixel;
    endfunction

    task automatic queue_colour(int unsigned h, int unsigned s, int unsigned v, bit drain);
        t_pending_colour entry;
        entry.colour.hue        = h[12:0];
        entry.colour.saturation = s[8:0];
        entry.colour.brightness = v[8:0];
        entry.drain_first       = drain;
        colour_queue.push_back(entry);
        colours_total++;
    endtask

    // Mostly in-range colours with a lean towards sector edges and unity levels
    task automatic queue_random_colour(bit drain);
        int unsigned h, s, v, edge_hue, circle, sector_len, one;
        circle     = int'(hsv2grb_pkg::HUE_CIRCLE);
        sector_len = int'(hsv2grb_pkg::HUE_SECTOR);
        one        = int'(hsv2grb_pkg::Q_ONE);
        if ($urandom_range(0, 99) < 75) begin
            h = $urandom_range(0, circle);
            if ($urandom_range(0, 9) == 0) begin
                edge_hue = $urandom_range(0, 6) * sector_len + $urandom_range(0, 2);
                h = (edge_hue == 0) ? 0 : edge_hue - 1;
                if (h > circle)
                    h = circle;
            end
            s = ($urandom_range(0, 99) < 15) ? ($urandom_range(0, 1) * one)
                                             : $urandom_range(0, one);
            v = ($urandom_range(0, 99) < 15) ? $urandom_range(one - 1, one)
                                             : $urandom_range(0, one);
        end else begin
            h = $urandom_range(0, 8191);
            s = $urandom_range(0, 511);
            v = $urandom_range(0, 511);
        end
        queue_colour(h, s, v, drain);
    endtask

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        $display("[%0t] MISMATCH %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // Driver: hold a colour until accepted, then launch the next or idle
    always @(posedge i_clk) begin : drive
        bit accepted;
        bit idle_now;
        accepted = start && !busy;
        if (accepted) begin
            expected_pixels.push_back(predict_pixel(i_item));
            colours_accepted++;
        end
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || accepted) begin
            idle_now = ($urandom_range(0, 99) < IDLE_PERCENT)
                    && !(colours_launched >= BURST_FIRST && colours_launched < BURST_LAST);
            if (colour_queue.size() != 0 && !idle_now
                    && !(colour_queue[0].drain_first && expected_pixels.size() != 0)) begin
                if (colour_queue[0].drain_first)
                    drains_done++;
                i_item <= colour_queue[0].colour;
                start  <= 1'b1;
                colour_queue.pop_front();
                colours_launched++;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each strobed pixel with the oldest prediction
    always @(posedge i_clk) begin : watch
        hsv2grb_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("pixel with no colour pending", '0, 32'(o_result));
            end else begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (o_result.invalid === 1'b1)
                    invalid_seen++;
                if (o_result.pixel_word !== want.pixel_word)
                    report_mismatch("pixel_word", 32'(want.pixel_word),
                                    32'(o_result.pixel_word));
                if (o_result.invalid !== want.invalid)
                    report_mismatch("invalid", 32'(want.invalid), 32'(o_result.invalid));
            end
        end
    end

    // Watchdog: stop a hung run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("hsv_to_grb_pixel_core_tb failed");
            $finish;
        end
    end

    initial begin
        // Directed colours: red, sector edges and midpoints, the wrap and every range fault
        queue_colour(0,    256, 256, 1'b0);
        queue_colour(5760, 256, 256, 1'b0);
        queue_colour(5759, 256, 256, 1'b0);
        queue_colour(959,  256, 256, 1'b0);
        queue_colour(960,  256, 256, 1'b0);
        queue_colour(1440, 256, 256, 1'b0);
        queue_colour(2400, 128, 200, 1'b0);
        queue_colour(3360, 200, 256, 1'b0);
        queue_colour(4320, 256, 100, 1'b0);
        queue_colour(5280, 64,  256, 1'b0);
        queue_colour(480,  0,   256, 1'b0);
        queue_colour(1000, 256, 0,   1'b0);
        queue_colour(5761, 0,   0,   1'b0);
        queue_colour(8191, 0,   0,   1'b0);
        queue_colour(0,    257, 0,   1'b0);
        queue_colour(0,    511, 256, 1'b0);
        queue_colour(0,    0,   257, 1'b0);
        queue_colour(0,    0,   511, 1'b0);
        queue_colour(8191, 511, 511, 1'b0);
        queue_colour(4799, 255, 255, 1'b0);
        queue_colour(4800, 1,   1,   1'b0);
        queue_colour(2879, 170, 85,  1'b0);

        // Random colours; drain the pipe before the first and now and then after
        for (int unsigned n = 0; n < RANDOM_COLOURS; n++)
            queue_random_colour(n == 0 || $urandom_range(0, 149) == 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every colour to be taken, then for the pipe to empty
        while (colours_accepted != colours_total)
            @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("sent %0d colours (%0d with the pipe drained first), checked %0d pixels,",
                 colours_accepted, drains_done, pixels_checked);
        $display("%0d of them flagged out of range, %0d mismatches", invalid_seen, mismatches);
        if (mismatches == 0) begin
            $display("hsv_to_grb_pixel_core_tb passed");
        end else begin
            $display("hsv_to_grb_pixel_core_tb failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/hsv2grb_pkg.sv
hw/rtl/hsv_to_grb_pixel_core.sv
tb/hsv_to_grb_pixel_core_tb.sv
